>>> hdl/a2b_pkg.sv
// Package for the AVCC to Annex B converter: item types, phase codes and result kinds.
`default_nettype none

package a2b_pkg;

  localparam int MAX_RES = 5;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  // Parser phases.
  localparam logic [3:0] PH_TYPE   = 4'd0;
  localparam logic [3:0] PH_RSKIP  = 4'd1;
  localparam logic [3:0] PH_RLSIZE = 4'd2;
  localparam logic [3:0] PH_RCOUNT = 4'd3;
  localparam logic [3:0] PH_RPLEN  = 4'd4;
  localparam logic [3:0] PH_RPDATA = 4'd5;
  localparam logic [3:0] PH_RDONE  = 4'd6;
  localparam logic [3:0] PH_VSKIP  = 4'd7;
  localparam logic [3:0] PH_VLEN   = 4'd8;
  localparam logic [3:0] PH_VDATA  = 4'd9;
  localparam logic [3:0] PH_IGNORE = 4'd10;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_OK    = 2'd1;
  localparam logic [1:0] KIND_UNSUP = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_ONE    = 8'h01;
  localparam logic [7:0] BYTE_ESCAPE = 8'h03;
  localparam logic [7:0] SPS_MASK    = 8'h1F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       msg_last;
  } a2b_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       run_last;
  } a2b_out_t;

  // All results caused by one input item, slot 0 first.
  typedef struct packed {
    logic [CNT_W-1:0]            count;
    a2b_out_t [MAX_RES-1:0]      slot;
  } a2b_bundle_t;

endpackage

`default_nettype wire

>>> hdl/avcc_to_annexb_converter_top.sv
// Top level of the AVCC to Annex B converter.
//
//   channel  direction  handshake              item
//   in_      input      in_valid / in_stall    a2b_in_t  (in_byte, msg_last)
//   out_     output     out_valid / out_stall  a2b_out_t (out_byte, out_kind, run_last)
//
// Each input byte is parsed in the cycle it is accepted; its 0 to 5 results
// appear from the result register on the next cycle, one per cycle unless stalled.
// An item with several results holds the input until they are taken, so the rate
// is one byte per cycle unless stalled, except on start codes, escapes, status words.
// The input is stalled until the last result in the result register is taken.
// Synchronous active-low reset returns the parser to the message type phase
// with a length size of four and empties the result register.
`default_nettype none

module avcc_to_annexb_converter_top (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  a2b_pkg::a2b_in_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output a2b_pkg::a2b_out_t  out_data
);
  import a2b_pkg::*;

  a2b_bundle_t bundle;
  logic        accept;
  logic        free;

  assign in_stall = !free;
  assign accept   = in_valid && free;

  a2b_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .bundle  (bundle)
  );

  a2b_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept && (bundle.count != '0)),
    .new_bundle (bundle),
    .free       (free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

>>> hdl/a2b_parse.sv
// Message parser: phase state, length tracking, start codes, escaping and status.
`default_nettype none

module a2b_parse (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  accept,
  input  a2b_pkg::a2b_in_t     in_item,
  output a2b_pkg::a2b_bundle_t bundle
);
  import a2b_pkg::*;

  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  field_counter_r, field_counter_nxt;
  logic [31:0] length_accum_r, length_accum_nxt;
  logic [31:0] bytes_remaining_r, bytes_remaining_nxt;
  logic [2:0]  length_field_bytes_r, length_field_bytes_nxt;
  logic [7:0]  sets_remaining_r, sets_remaining_nxt;
  logic        in_pps_list_r, in_pps_list_nxt;
  logic [1:0]  zero_run_r, zero_run_nxt;

  logic [7:0]  b;
  logic [2:0]  fc_inc;
  logic [31:0] la_shift;
  logic [31:0] br_dec;
  logic        do_start;
  logic        do_pay;
  logic        do_pdone;
  logic        escape;
  logic [1:0]  status;
  logic [CNT_W-1:0]       n;
  a2b_out_t [MAX_RES-1:0] res;

  assign b        = in_item.in_byte;
  assign fc_inc   = field_counter_r + 3'd1;
  assign la_shift = {length_accum_r[23:0], b};
  assign br_dec   = bytes_remaining_r - 32'd1;
  assign escape   = (zero_run_r >= 2'd2) && (b == BYTE_ZERO);

  always_comb begin
    phase_nxt              = phase_r;
    field_counter_nxt      = field_counter_r;
    length_accum_nxt       = length_accum_r;
    bytes_remaining_nxt    = bytes_remaining_r;
    length_field_bytes_nxt = length_field_bytes_r;
    sets_remaining_nxt     = sets_remaining_r;
    in_pps_list_nxt        = in_pps_list_r;
    zero_run_nxt           = zero_run_r;
    do_start               = 1'b0;
    do_pay                 = 1'b0;
    do_pdone               = 1'b0;

    case (phase_r)
      PH_TYPE: begin
        field_counter_nxt = 3'd0;
        length_accum_nxt  = 32'd0;
        in_pps_list_nxt   = 1'b0;
        if (b == 8'd0) begin
          phase_nxt = PH_RSKIP;
        end else if (b == 8'd1) begin
          phase_nxt = PH_VSKIP;
        end else begin
          phase_nxt = PH_IGNORE;
        end
      end
      PH_RSKIP: begin
        if (fc_inc == 3'd7) begin
          field_counter_nxt = 3'd0;
          phase_nxt         = PH_RLSIZE;
        end else begin
          field_counter_nxt = fc_inc;
        end
      end
      PH_RLSIZE: begin
        length_field_bytes_nxt = {1'b0, b[1:0]} + 3'd1;
        phase_nxt              = PH_RCOUNT;
      end
      PH_RCOUNT: begin
        sets_remaining_nxt = in_pps_list_r ? b : (b & SPS_MASK);
        field_counter_nxt  = 3'd0;
        length_accum_nxt   = 32'd0;
        if (sets_remaining_nxt != 8'd0) begin
          phase_nxt = PH_RPLEN;
        end else if (!in_pps_list_r) begin
          in_pps_list_nxt = 1'b1;
        end else begin
          phase_nxt = PH_RDONE;
        end
      end
      PH_RPLEN: begin
        length_accum_nxt  = la_shift;
        field_counter_nxt = fc_inc;
        if (fc_inc >= 3'd2) begin
          do_start            = 1'b1;
          bytes_remaining_nxt = {16'd0, la_shift[15:0]};
          if (la_shift[15:0] == 16'd0) begin
            do_pdone = 1'b1;
          end else begin
            phase_nxt = PH_RPDATA;
          end
        end
      end
      PH_RPDATA: begin
        do_pay              = 1'b1;
        bytes_remaining_nxt = br_dec;
        if (br_dec == 32'd0) begin
          do_pdone = 1'b1;
        end
      end
      PH_VSKIP: begin
        if (fc_inc >= 3'd3) begin
          field_counter_nxt = 3'd0;
          length_accum_nxt  = 32'd0;
          phase_nxt         = PH_VLEN;
        end else begin
          field_counter_nxt = fc_inc;
        end
      end
      PH_VLEN: begin
        if (fc_inc >= length_field_bytes_r) begin
          do_start            = 1'b1;
          bytes_remaining_nxt = la_shift;
          field_counter_nxt   = 3'd0;
          length_accum_nxt    = 32'd0;
          if (la_shift != 32'd0) begin
            phase_nxt = PH_VDATA;
          end
        end else begin
          length_accum_nxt  = la_shift;
          field_counter_nxt = fc_inc;
        end
      end
      PH_VDATA: begin
        do_pay              = 1'b1;
        bytes_remaining_nxt = br_dec;
        if (br_dec == 32'd0) begin
          field_counter_nxt = 3'd0;
          length_accum_nxt  = 32'd0;
          phase_nxt         = PH_VLEN;
        end
      end
      default: begin
      end
    endcase

    // A parameter set is finished: go to the next set, the PPS list or done.
    if (do_pdone) begin
      sets_remaining_nxt = sets_remaining_r - 8'd1;
      field_counter_nxt  = 3'd0;
      length_accum_nxt   = 32'd0;
      if (sets_remaining_nxt != 8'd0) begin
        phase_nxt = PH_RPLEN;
      end else if (!in_pps_list_r) begin
        in_pps_list_nxt = 1'b1;
        phase_nxt       = PH_RCOUNT;
      end else begin
        phase_nxt = PH_RDONE;
      end
    end

    if (do_start) begin
      zero_run_nxt = 2'd0;
    end else if (do_pay) begin
      if (escape) begin
        zero_run_nxt = 2'd1;
      end else if (b == BYTE_ZERO) begin
        zero_run_nxt = (zero_run_r < 2'd2) ? zero_run_r + 2'd1 : 2'd2;
      end else begin
        zero_run_nxt = 2'd0;
      end
    end

    if (phase_nxt == PH_IGNORE) begin
      status = KIND_UNSUP;
    end else if (phase_nxt == PH_RDONE) begin
      status = KIND_OK;
    end else if ((phase_nxt == PH_VLEN) && (field_counter_nxt == 3'd0)) begin
      status = KIND_OK;
    end else begin
      status = KIND_TRUNC;
    end

    if (in_item.msg_last) begin
      phase_nxt           = PH_TYPE;
      field_counter_nxt   = 3'd0;
      length_accum_nxt    = 32'd0;
      bytes_remaining_nxt = 32'd0;
      sets_remaining_nxt  = 8'd0;
      in_pps_list_nxt     = 1'b0;
      zero_run_nxt        = 2'd0;
    end
  end

  // Result list: a start code or one or two payload bytes, then on a last byte the status.
  always_comb begin
    res = '0;
    n   = '0;
    if (do_start) begin
      res[0].out_byte = BYTE_ZERO;
      res[1].out_byte = BYTE_ZERO;
      res[2].out_byte = BYTE_ZERO;
      res[3].out_byte = BYTE_ONE;
      n = CNT_W'(4);
    end else if (do_pay) begin
      if (escape) begin
        res[0].out_byte = BYTE_ESCAPE;
        res[1].out_byte = BYTE_ZERO;
        n = CNT_W'(2);
      end else begin
        res[0].out_byte = b;
        n = CNT_W'(1);
      end
    end
    if (in_item.msg_last) begin
      res[n].out_byte = BYTE_ZERO;
      res[n].out_kind = status;
      n = n + CNT_W'(1);
    end
    for (int i = 0; i < MAX_RES; i++) begin
      res[i].run_last = (n != '0) && (CNT_W'(i) == n - CNT_W'(1));
    end
  end

  assign bundle.count = n;
  assign bundle.slot  = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r              <= PH_TYPE;
      field_counter_r      <= 3'd0;
      length_accum_r       <= 32'd0;
      bytes_remaining_r    <= 32'd0;
      length_field_bytes_r <= 3'd4;
      sets_remaining_r     <= 8'd0;
      in_pps_list_r        <= 1'b0;
      zero_run_r           <= 2'd0;
    end else if (accept) begin
      phase_r              <= phase_nxt;
      field_counter_r      <= field_counter_nxt;
      length_accum_r       <= length_accum_nxt;
      bytes_remaining_r    <= bytes_remaining_nxt;
      length_field_bytes_r <= length_field_bytes_nxt;
      sets_remaining_r     <= sets_remaining_nxt;
      in_pps_list_r        <= in_pps_list_nxt;
      zero_run_r           <= zero_run_nxt;
    end
  end

  a_len_counter: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_VLEN) |-> (field_counter_r < length_field_bytes_r))
    else $error("length field counter passed the length size");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_RPDATA) || (phase_r == PH_VDATA)) |-> (bytes_remaining_r != 32'd0))
    else $error("data phase with no bytes remaining");

  a_len_size: assert property (@(posedge clk) disable iff (!rst_n)
    (length_field_bytes_r != 3'd0) && (length_field_bytes_r <= 3'd4))
    else $error("length size out of range");

endmodule

`default_nettype wire

>>> hdl/a2b_emit.sv
// Result register: holds one item's results; one leaves per cycle unless stalled.
`default_nettype none

module a2b_emit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  load,
  input  a2b_pkg::a2b_bundle_t new_bundle,
  output logic                 free,
  output logic                 out_valid,
  input  wire                  out_stall,
  output a2b_pkg::a2b_out_t    out_data
);
  import a2b_pkg::*;

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  a2b_out_t [MAX_RES-1:0] slot_r, slot_nxt;
  logic                   take;

  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[0];
  assign take      = out_valid && !out_stall;
  // The register can take a new item once its last result leaves.
  assign free      = !out_valid || (take && (cnt_r == CNT_W'(1)));

  always_comb begin
    cnt_nxt  = cnt_r;
    slot_nxt = slot_r;
    if (load) begin
      cnt_nxt  = new_bundle.count;
      slot_nxt = new_bundle.slot;
    end else if (take) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      for (int i = 0; i < MAX_RES - 1; i++) begin
        slot_nxt[i] = slot_r[i + 1];
      end
      slot_nxt[MAX_RES-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.run_last == (cnt_r == CNT_W'(1))))
    else $error("run_last does not match the final queued result");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid || (take && (cnt_r == CNT_W'(1)))))
    else $error("new results loaded over pending ones");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (cnt_r == CNT_W'(1)) && !load) |=> !out_valid)
    else $error("result register did not drain");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && !load) |=> $stable(cnt_r))
    else $error("result count changed while stalled");

endmodule

`default_nettype wire
